// ----- hw/rtl/bpa_pkg.sv -----
// Buddy page allocator: shared types, field widths and codes.
// Used by bpa_ctrl, bpa_dpath and the top level in hw/rtl; depends on nothing.
package bpa_pkg;

  localparam int CMD_W = 2;
  localparam int ORD_W = 4;
  localparam int IDX_W = 12;
  localparam int STS_W = 2;
  localparam int CFG_W = 13;
  localparam int HO_W  = 5;

  localparam logic [CFG_W-1:0] USABLE_RESET = 13'd4096;
  localparam logic [HO_W-1:0]  NO_ORDER     = 5'd31;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REBUILD = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

  localparam logic [STS_W-1:0] RES_OK        = 2'd0;
  localparam logic [STS_W-1:0] RES_NO_FREE   = 2'd1;
  localparam logic [STS_W-1:0] RES_NOT_ALLOC = 2'd2;
  localparam logic [STS_W-1:0] RES_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ORD_W-1:0] block_order;
    logic [IDX_W-1:0] page_index;
  } req_t;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [IDX_W-1:0] block_start;
  } rsp_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_INIT,
    DP_SWEEP,
    DP_SEARCH,
    DP_RD_P,
    DP_RD_B,
    DP_UNLINK,
    DP_SPLIT_A,
    DP_SPLIT_B,
    DP_ALLOC_FIN,
    DP_FREE_CLR,
    DP_MERGE,
    DP_HEAD_A,
    DP_HEAD_B,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [STS_W-1:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic no_free;
    logic hit;
    logic bad_index;
    logic not_alloc;
    logic merge_ok;
    logic can_try;
    logic split_more;
    logic sweep_last;
  } dp_status_t;

endpackage

// ----- hw/rtl/bpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module bpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bpa_ctrl.sv -----
// Buddy page allocator controller: sequences each transaction as datapath ops.
// Depends on bpa_pkg.
module bpa_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [bpa_pkg::CMD_W-1:0] cmd_i,
  output logic                     busy_o,
  output bpa_pkg::dp_cmd_t         dp_cmd_o,
  input  bpa_pkg::dp_status_t      dp_sts_i
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_INIT   = 5'd1;
  localparam logic [4:0] S_SWEEP  = 5'd2;
  localparam logic [4:0] S_SEARCH = 5'd3;
  localparam logic [4:0] S_UREAD  = 5'd4;
  localparam logic [4:0] S_UNLINK = 5'd5;
  localparam logic [4:0] S_SPLITA = 5'd6;
  localparam logic [4:0] S_SPLITB = 5'd7;
  localparam logic [4:0] S_AFIN   = 5'd8;
  localparam logic [4:0] S_FCHK   = 5'd9;
  localparam logic [4:0] S_FRD    = 5'd10;
  localparam logic [4:0] S_FTEST  = 5'd11;
  localparam logic [4:0] S_MTEST  = 5'd12;
  localparam logic [4:0] S_MREAD  = 5'd13;
  localparam logic [4:0] S_MCHK   = 5'd14;
  localparam logic [4:0] S_HEADA  = 5'd15;
  localparam logic [4:0] S_HEADB  = 5'd16;
  localparam logic [4:0] S_EMIT   = 5'd17;

  logic [4:0]                state_q, state_d;
  logic [bpa_pkg::STS_W-1:0] code_q, code_d;
  logic                      report_q, report_d;

  always_comb begin
    state_d       = state_q;
    code_d        = code_q;
    report_d      = report_q;
    dp_cmd_o.op   = bpa_pkg::DP_NONE;
    dp_cmd_o.code = code_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          dp_cmd_o.op = bpa_pkg::DP_LOAD;
          case (cmd_i)
            bpa_pkg::CMD_ALLOC: state_d = S_SEARCH;
            bpa_pkg::CMD_FREE:  state_d = S_FCHK;
            bpa_pkg::CMD_REBUILD: begin
              state_d  = S_INIT;
              report_d = 1'b1;
            end
            default: begin
              state_d = S_EMIT;
              code_d  = bpa_pkg::RES_OK;
            end
          endcase
        end
      end
      S_INIT: begin
        dp_cmd_o.op = bpa_pkg::DP_INIT;
        state_d     = S_SWEEP;
      end
      S_SWEEP: begin
        dp_cmd_o.op = bpa_pkg::DP_SWEEP;
        if (dp_sts_i.sweep_last) begin
          if (report_q) begin
            state_d  = S_EMIT;
            code_d   = bpa_pkg::RES_OK;
            report_d = 1'b0;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SEARCH: begin
        dp_cmd_o.op = bpa_pkg::DP_SEARCH;
        if (dp_sts_i.no_free) begin
          state_d = S_EMIT;
          code_d  = bpa_pkg::RES_NO_FREE;
        end else if (dp_sts_i.hit) begin
          state_d = S_UREAD;
        end
      end
      S_UREAD: begin
        dp_cmd_o.op = bpa_pkg::DP_RD_P;
        state_d     = S_UNLINK;
      end
      S_UNLINK: begin
        dp_cmd_o.op = bpa_pkg::DP_UNLINK;
        state_d     = dp_sts_i.split_more ? S_SPLITA : S_AFIN;
      end
      S_SPLITA: begin
        dp_cmd_o.op = bpa_pkg::DP_SPLIT_A;
        state_d     = S_SPLITB;
      end
      S_SPLITB: begin
        dp_cmd_o.op = bpa_pkg::DP_SPLIT_B;
        state_d     = dp_sts_i.split_more ? S_SPLITA : S_AFIN;
      end
      S_AFIN: begin
        dp_cmd_o.op = bpa_pkg::DP_ALLOC_FIN;
        state_d     = S_EMIT;
        code_d      = bpa_pkg::RES_OK;
      end
      S_FCHK: begin
        if (dp_sts_i.bad_index) begin
          state_d = S_EMIT;
          code_d  = bpa_pkg::RES_BAD_INDEX;
        end else begin
          state_d = S_FRD;
        end
      end
      S_FRD: begin
        dp_cmd_o.op = bpa_pkg::DP_RD_P;
        state_d     = S_FTEST;
      end
      S_FTEST: begin
        if (dp_sts_i.not_alloc) begin
          state_d = S_EMIT;
          code_d  = bpa_pkg::RES_NOT_ALLOC;
        end else begin
          dp_cmd_o.op = bpa_pkg::DP_FREE_CLR;
          state_d     = S_MTEST;
        end
      end
      S_MTEST: begin
        state_d = dp_sts_i.can_try ? S_MREAD : S_HEADA;
      end
      S_MREAD: begin
        dp_cmd_o.op = bpa_pkg::DP_RD_B;
        state_d     = S_MCHK;
      end
      S_MCHK: begin
        dp_cmd_o.op = bpa_pkg::DP_MERGE;
        state_d     = dp_sts_i.merge_ok ? S_MTEST : S_HEADA;
      end
      S_HEADA: begin
        dp_cmd_o.op = bpa_pkg::DP_HEAD_A;
        state_d     = S_HEADB;
      end
      S_HEADB: begin
        dp_cmd_o.op = bpa_pkg::DP_HEAD_B;
        state_d     = S_EMIT;
        code_d      = bpa_pkg::RES_OK;
      end
      S_EMIT: begin
        dp_cmd_o.op = bpa_pkg::DP_EMIT;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      code_q   <= bpa_pkg::RES_OK;
      report_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      code_q   <= code_d;
      report_q <= report_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- hw/rtl/bpa_dpath.sv -----
// Buddy page allocator datapath: per-page RAMs, list end registers, op execution.
// Depends on bpa_pkg and bpa_ram.
module bpa_dpath #(
  parameter int PAGES  = 4096,
  parameter int ORDERS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [bpa_pkg::ORD_W-1:0] block_order_i,
  input  logic [bpa_pkg::IDX_W-1:0] page_index_i,
  input  logic                      cfg_we_i,
  input  logic [bpa_pkg::CFG_W-1:0] cfg_wdata_i,
  input  bpa_pkg::dp_cmd_t          dp_cmd_i,
  output bpa_pkg::dp_status_t       dp_sts_o,
  output logic                      strobe_o,
  output bpa_pkg::rsp_t             rsp_o
);

  localparam int AW  = $clog2(PAGES);
  localparam int LW  = AW + 1;
  localparam int XW  = $clog2(ORDERS);
  localparam int TOP = ORDERS - 1;
  localparam int MW  = (bpa_pkg::CFG_W > LW) ? bpa_pkg::CFG_W : LW;
  localparam int SZW = ((LW > ORDERS) ? LW : ORDERS) + 1;
  localparam int HW  = bpa_pkg::HO_W;
  localparam logic [LW-1:0] NIL = LW'(PAGES);

  logic [bpa_pkg::CFG_W-1:0] usable_q;
  logic [LW-1:0]             managed_q;
  logic [AW-1:0]             cnt_q;
  logic                      strobe_q;
  logic [LW-1:0]             first_q [ORDERS];
  logic [LW-1:0]             last_q  [ORDERS];
  logic [AW-1:0]             p_q;
  logic [HW-1:0]             o_q;
  logic [bpa_pkg::ORD_W-1:0] ord_q;
  logic [bpa_pkg::IDX_W-1:0] idx_q;
  logic [LW-1:0]             l_q;
  logic [AW-1:0]             start_q;
  bpa_pkg::rsp_t             rsp_q;

  logic          busy_we, ord_we, prev_we, next_we;
  logic [AW-1:0] busy_wa, ord_wa, prev_wa, next_wa, raddr;
  logic          busy_wd, rd_busy;
  logic [HW-1:0] ord_wd, rd_order;
  logic [LW-1:0] prev_wd, next_wd, rd_prev, rd_next;

  bpa_ram #(.Width(1), .Depth(PAGES)) u_busy_ram (
    .clk_i, .we_i(busy_we), .waddr_i(busy_wa), .wdata_i(busy_wd),
    .raddr_i(raddr), .rdata_o(rd_busy)
  );
  bpa_ram #(.Width(HW), .Depth(PAGES)) u_order_ram (
    .clk_i, .we_i(ord_we), .waddr_i(ord_wa), .wdata_i(ord_wd),
    .raddr_i(raddr), .rdata_o(rd_order)
  );
  bpa_ram #(.Width(LW), .Depth(PAGES)) u_prev_ram (
    .clk_i, .we_i(prev_we), .waddr_i(prev_wa), .wdata_i(prev_wd),
    .raddr_i(raddr), .rdata_o(rd_prev)
  );
  bpa_ram #(.Width(LW), .Depth(PAGES)) u_next_ram (
    .clk_i, .we_i(next_we), .waddr_i(next_wa), .wdata_i(next_wd),
    .raddr_i(raddr), .rdata_o(rd_next)
  );

  // list layout and per-page layout arithmetic
  logic [LW-1:0] m_new, topend_n, topend, topsize, c;
  logic          is_top, is_one;
  logic [HW-1:0] sw_order;
  logic [LW-1:0] sw_prev, sw_next;

  assign m_new    = (MW'(usable_q) > MW'(PAGES)) ? NIL : LW'(usable_q);
  assign topsize  = LW'(1) << TOP;
  assign topend_n = (m_new >> TOP) << TOP;
  assign topend   = (managed_q >> TOP) << TOP;
  assign c        = LW'(cnt_q);
  assign is_top   = (c < topend) && ((c & (topsize - LW'(1))) == '0);
  assign is_one   = (c >= topend) && (c < managed_q);

  always_comb begin
    sw_order = bpa_pkg::NO_ORDER;
    sw_prev  = NIL;
    sw_next  = NIL;
    if (is_top) begin
      sw_order = HW'(TOP);
      sw_prev  = (c == '0) ? NIL : c - topsize;
      sw_next  = (c + topsize == topend) ? NIL : c + topsize;
    end else if (is_one) begin
      sw_order = '0;
      sw_prev  = (c == topend) ? NIL : c - LW'(1);
      sw_next  = (c + LW'(1) == managed_q) ? NIL : c + LW'(1);
    end
  end

  // order indexes and buddy
  logic [HW-1:0]  om1;
  logic [XW-1:0]  oi, om1i;
  logic [LW-1:0]  first_sel, last_m1;
  logic [SZW-1:0] size, b_w;
  logic [AW-1:0]  b_a;
  logic [15:0]    align_mask;

  assign om1       = o_q - HW'(1);
  assign oi        = o_q[XW-1:0];
  assign om1i      = om1[XW-1:0];
  assign first_sel = first_q[oi];
  assign last_m1   = last_q[om1i];
  assign size      = SZW'(1) << o_q;
  assign b_w       = SZW'(p_q) ^ size;
  assign b_a       = b_w[AW-1:0];
  assign align_mask = (16'(1) << ord_q) - 16'(1);

  assign dp_sts_o.no_free    = (o_q >= HW'(ORDERS));
  assign dp_sts_o.hit        = !dp_sts_o.no_free && (first_sel != NIL);
  assign dp_sts_o.bad_index  = (MW'(idx_q) >= MW'(managed_q)) ||
                               (HW'(ord_q) >= HW'(ORDERS)) ||
                               ((16'(idx_q) & align_mask) != '0);
  assign dp_sts_o.not_alloc  = !rd_busy || (rd_order != HW'(ord_q));
  assign dp_sts_o.merge_ok   = !rd_busy && (rd_order == o_q);
  assign dp_sts_o.can_try    = (o_q < HW'(TOP)) && (b_w + size <= SZW'(managed_q));
  assign dp_sts_o.split_more = (o_q > HW'(ord_q));
  assign dp_sts_o.sweep_last = (cnt_q == AW'(PAGES - 1));

  assign raddr = (dp_cmd_i.op == bpa_pkg::DP_RD_B) ? b_a : p_q;

  always_comb begin
    busy_we = 1'b0; busy_wa = p_q; busy_wd = 1'b0;
    ord_we  = 1'b0; ord_wa  = p_q; ord_wd  = bpa_pkg::NO_ORDER;
    prev_we = 1'b0; prev_wa = p_q; prev_wd = NIL;
    next_we = 1'b0; next_wa = p_q; next_wd = NIL;
    case (dp_cmd_i.op)
      bpa_pkg::DP_SWEEP: begin
        busy_we = 1'b1; busy_wa = cnt_q;
        ord_we  = 1'b1; ord_wa  = cnt_q; ord_wd  = sw_order;
        prev_we = 1'b1; prev_wa = cnt_q; prev_wd = sw_prev;
        next_we = 1'b1; next_wa = cnt_q; next_wd = sw_next;
      end
      bpa_pkg::DP_UNLINK, bpa_pkg::DP_MERGE: begin
        if (dp_cmd_i.op == bpa_pkg::DP_UNLINK || dp_sts_o.merge_ok) begin
          if (rd_prev != NIL) begin
            next_we = 1'b1; next_wa = rd_prev[AW-1:0]; next_wd = rd_next;
          end
          if (rd_next != NIL) begin
            prev_we = 1'b1; prev_wa = rd_next[AW-1:0]; prev_wd = rd_prev;
          end
          if (dp_cmd_i.op == bpa_pkg::DP_MERGE) begin
            ord_we = 1'b1; ord_wa = b_a;
          end
        end
      end
      bpa_pkg::DP_SPLIT_A: begin
        ord_we  = 1'b1; ord_wd = om1;
        prev_we = 1'b1; prev_wd = last_m1;
        next_we = 1'b1;
      end
      bpa_pkg::DP_SPLIT_B: begin
        if (l_q != NIL) begin
          next_we = 1'b1; next_wa = l_q[AW-1:0]; next_wd = LW'(p_q);
        end
      end
      bpa_pkg::DP_ALLOC_FIN: begin
        ord_we  = 1'b1; ord_wd = HW'(ord_q);
        busy_we = 1'b1; busy_wd = 1'b1;
      end
      bpa_pkg::DP_FREE_CLR: begin
        ord_we  = 1'b1;
        busy_we = 1'b1;
      end
      bpa_pkg::DP_HEAD_A: begin
        ord_we  = 1'b1; ord_wd = o_q;
        prev_we = 1'b1;
        next_we = 1'b1; next_wd = first_sel;
      end
      bpa_pkg::DP_HEAD_B: begin
        if (l_q != NIL) begin
          prev_we = 1'b1; prev_wa = l_q[AW-1:0]; prev_wd = LW'(p_q);
        end
      end
      default: begin
      end
    endcase
  end

  // list ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ORDERS; i++) begin
        first_q[i] <= NIL;
        last_q[i]  <= NIL;
      end
    end else begin
      case (dp_cmd_i.op)
        bpa_pkg::DP_INIT: begin
          for (int i = 0; i < ORDERS; i++) begin
            first_q[i] <= NIL;
            last_q[i]  <= NIL;
          end
          if (topend_n != '0) begin
            first_q[TOP] <= '0;
            last_q[TOP]  <= topend_n - topsize;
          end
          if (topend_n < m_new) begin
            first_q[0] <= topend_n;
            last_q[0]  <= m_new - LW'(1);
          end
        end
        bpa_pkg::DP_UNLINK, bpa_pkg::DP_MERGE: begin
          if (dp_cmd_i.op == bpa_pkg::DP_UNLINK || dp_sts_o.merge_ok) begin
            if (rd_prev == NIL) first_q[oi] <= rd_next;
            if (rd_next == NIL) last_q[oi]  <= rd_prev;
          end
        end
        bpa_pkg::DP_SPLIT_A: begin
          if (last_m1 == NIL) first_q[om1i] <= LW'(p_q);
          last_q[om1i] <= LW'(p_q);
        end
        bpa_pkg::DP_HEAD_A: begin
          if (first_sel == NIL) last_q[oi] <= LW'(p_q);
          first_q[oi] <= LW'(p_q);
        end
        default: begin
        end
      endcase
    end
  end

  // configuration, layout sweep and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usable_q  <= bpa_pkg::USABLE_RESET;
      managed_q <= '0;
      cnt_q     <= '0;
      strobe_q  <= 1'b0;
    end else begin
      if (cfg_we_i) usable_q <= cfg_wdata_i;
      if (dp_cmd_i.op == bpa_pkg::DP_INIT) begin
        managed_q <= m_new;
        cnt_q     <= '0;
      end else if (dp_cmd_i.op == bpa_pkg::DP_SWEEP) begin
        cnt_q <= cnt_q + AW'(1);
      end
      strobe_q <= (dp_cmd_i.op == bpa_pkg::DP_EMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    case (dp_cmd_i.op)
      bpa_pkg::DP_LOAD: begin
        ord_q   <= block_order_i;
        idx_q   <= page_index_i;
        p_q     <= AW'(page_index_i);
        o_q     <= HW'(block_order_i);
        start_q <= '0;
      end
      bpa_pkg::DP_SEARCH: begin
        if (!dp_sts_o.no_free) begin
          if (dp_sts_o.hit) p_q <= first_sel[AW-1:0];
          else              o_q <= o_q + HW'(1);
        end
      end
      bpa_pkg::DP_SPLIT_A: begin
        o_q <= om1;
        l_q <= last_m1;
      end
      bpa_pkg::DP_SPLIT_B: p_q <= p_q + (AW'(1) << o_q);
      bpa_pkg::DP_ALLOC_FIN: start_q <= p_q;
      bpa_pkg::DP_MERGE: begin
        if (dp_sts_o.merge_ok) begin
          if (b_a < p_q) p_q <= b_a;
          o_q <= o_q + HW'(1);
        end
      end
      bpa_pkg::DP_HEAD_A: l_q <= first_sel;
      bpa_pkg::DP_EMIT: begin
        rsp_q.status      <= dp_cmd_i.code;
        rsp_q.block_start <= bpa_pkg::IDX_W'(start_q);
      end
      default: begin
      end
    endcase
  end

  assign strobe_o = strobe_q;
  assign rsp_o    = rsp_q;

  a_split_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_i.op == bpa_pkg::DP_SPLIT_A |-> (o_q != '0) && (o_q > HW'(ord_q)))
    else $error("split below requested order");

  a_unlink_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_i.op == bpa_pkg::DP_UNLINK |-> $past(dp_cmd_i.op) == bpa_pkg::DP_RD_P)
    else $error("unlink without fresh read data");

  a_merge_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_i.op == bpa_pkg::DP_MERGE |-> $past(dp_cmd_i.op) == bpa_pkg::DP_RD_B)
    else $error("merge check without buddy read");

  a_head_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_i.op == bpa_pkg::DP_HEAD_A |-> o_q <= HW'(TOP))
    else $error("merged past top order");

endmodule

// ----- hw/rtl/buddy_page_allocator_top.sv -----
// Buddy page allocator top level: controller plus datapath.
// Depends on bpa_pkg, bpa_ctrl, bpa_dpath (and bpa_ram through it).
//
// One transaction at a time: start is taken when busy is low, and the single
// result is marked on rsp_o by strobe_o, high for exactly one cycle, with no
// way to hold it off. Busy stays high after the accepting edge while the
// controller steps through the command's sequence on the registered-read page
// RAMs: longer for each order searched and each split in an allocate and for
// each merge in a free, shorter for a rejected free or a no-op, and over every
// page for a rebuild. The strobe comes in the same cycle that busy drops.
// After reset the block lays out the page RAMs one entry per cycle and holds
// busy meanwhile; configuration writes are taken throughout.
module buddy_page_allocator_top #(
  parameter int PAGES  = 4096,
  parameter int ORDERS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  bpa_pkg::req_t             req_i,
  output logic                      strobe_o,
  output bpa_pkg::rsp_t             rsp_o,
  input  logic                      cfg_we_i,
  input  logic [bpa_pkg::CFG_W-1:0] cfg_wdata_i
);

  bpa_pkg::dp_cmd_t    dp_cmd;
  bpa_pkg::dp_status_t dp_sts;

  bpa_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i  (start),
    .cmd_i    (req_i.cmd),
    .busy_o   (busy),
    .dp_cmd_o (dp_cmd),
    .dp_sts_i (dp_sts)
  );

  bpa_dpath #(
    .PAGES  (PAGES),
    .ORDERS (ORDERS)
  ) u_dpath (
    .clk_i,
    .rst_ni,
    .block_order_i (req_i.block_order),
    .page_index_i  (req_i.page_index),
    .cfg_we_i,
    .cfg_wdata_i,
    .dp_cmd_i      (dp_cmd),
    .dp_sts_o      (dp_sts),
    .strobe_o,
    .rsp_o
  );

endmodule

// ----- tb/sv/buddy_page_allocator_checker.sv -----
// Checker for the buddy page allocator: watches requests, results and
// register writes, predicts each result and compares. Depends on bpa_pkg.
`timescale 1ns / 100ps
module buddy_page_allocator_checker
  import bpa_pkg::*;
#(
  parameter int PAGES  = 4096,
  parameter int ORDERS = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  req_t             req_i,
  input  logic             strobe_o,
  input  rsp_t             rsp_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output int               fail_count,
  output int               pending_rsp,
  output int               alloc_ok_count,
  output int               merge_count
);
  localparam int NILP = PAGES;
  localparam int TOP  = ORDERS - 1;

  int          usable;
  int          managed;
  bit          pg_busy[PAGES];
  int          head_ord[PAGES];
  int          nxt[PAGES];
  int          prv[PAGES];
  int          first_of[ORDERS];
  int          last_of[ORDERS];
  rsp_t        rsp_q[$];

  function automatic void unlink(int o, int p);
    int pr, nx;
    pr = prv[p];
    nx = nxt[p];
    if (pr == NILP) first_of[o] = nx; else nxt[pr] = nx;
    if (nx == NILP) last_of[o] = pr; else prv[nx] = pr;
    prv[p] = NILP;
    nxt[p] = NILP;
  endfunction

  function automatic void add_tail(int o, int p);
    nxt[p] = NILP;
    prv[p] = last_of[o];
    if (last_of[o] == NILP) first_of[o] = p; else nxt[last_of[o]] = p;
    last_of[o] = p;
  endfunction

  function automatic void add_head(int o, int p);
    prv[p] = NILP;
    nxt[p] = first_of[o];
    if (first_of[o] == NILP) last_of[o] = p; else prv[first_of[o]] = p;
    first_of[o] = p;
  endfunction

  function automatic void layout_pool();
    int tops;
    managed = (usable > PAGES) ? PAGES : usable;
    for (int i = 0; i < PAGES; i++) begin
      pg_busy[i] = 0;
      head_ord[i] = int'(NO_ORDER);
      nxt[i] = NILP;
      prv[i] = NILP;
    end
    for (int i = 0; i < ORDERS; i++) begin
      first_of[i] = NILP;
      last_of[i] = NILP;
    end
    tops = managed >> TOP;
    for (int i = 0; i < tops; i++) begin
      head_ord[i << TOP] = TOP;
      add_tail(TOP, i << TOP);
    end
    for (int p = tops << TOP; p < managed; p++) begin
      head_ord[p] = 0;
      add_tail(0, p);
    end
  endfunction

  function automatic rsp_t predict_rsp(req_t r);
    rsp_t res;
    int   ord, idx, o, p, sz, b;
    res = '0;
    res.status = RES_OK;
    ord = int'(r.block_order);
    idx = int'(r.page_index);
    if (r.cmd == CMD_ALLOC) begin
      o = ord;
      while (o < ORDERS && first_of[o] == NILP) o++;
      if (ord >= ORDERS || o >= ORDERS) begin
        res.status = RES_NO_FREE;
      end else begin
        p = first_of[o];
        unlink(o, p);
        while (o > ord) begin
          o--;
          head_ord[p] = o;
          add_tail(o, p);
          p += 1 << o;
        end
        head_ord[p] = ord;
        pg_busy[p] = 1;
        res.block_start = IDX_W'(p);
        alloc_ok_count++;
      end
    end else if (r.cmd == CMD_FREE) begin
      if (idx >= managed || ord >= ORDERS || (idx & ((1 << ord) - 1)) != 0) begin
        res.status = RES_BAD_INDEX;
      end else if (!pg_busy[idx] || head_ord[idx] != ord) begin
        res.status = RES_NOT_ALLOC;
      end else begin
        p = idx;
        o = ord;
        pg_busy[p] = 0;
        head_ord[p] = int'(NO_ORDER);
        while (o < TOP) begin
          sz = 1 << o;
          b = p ^ sz;
          if (b + sz > managed || pg_busy[b] || head_ord[b] != o) break;
          unlink(o, b);
          head_ord[b] = int'(NO_ORDER);
          if (b < p) p = b;
          o++;
          merge_count++;
        end
        head_ord[p] = o;
        add_head(o, p);
      end
    end else if (r.cmd == CMD_REBUILD) begin
      layout_pool();
    end
    return res;
  endfunction

  assign pending_rsp = rsp_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      usable = int'(USABLE_RESET);
      layout_pool();
      rsp_q.delete();
      fail_count = 0;
      alloc_ok_count = 0;
      merge_count = 0;
    end else begin
      if (strobe_o) begin
        if (rsp_q.size() == 0) begin
          $error("result with no transaction outstanding: %h", rsp_o);
          fail_count++;
        end else begin
          exp_rsp = rsp_q.pop_front();
          if (rsp_o.status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, rsp_o.status);
            fail_count++;
          end
          if (rsp_o.block_start !== exp_rsp.block_start) begin
            $error("block_start: expected %0d, got %0d",
                   exp_rsp.block_start, rsp_o.block_start);
            fail_count++;
          end
        end
      end
      if (start && !busy) rsp_q.push_back(predict_rsp(req_i));
      // register only takes effect on the next rebuild
      if (cfg_we_i) usable = int'(cfg_wdata_i);
    end
  end
endmodule

// ----- tb/sv/buddy_page_allocator_top_test.sv -----
// Testbench top for the buddy page allocator: clock, reset, stimulus and
// verdict. Depends on bpa_pkg, buddy_page_allocator_top and the checker.
`timescale 1ns / 100ps
module buddy_page_allocator_top_test;
  import bpa_pkg::*;

  localparam int PAGES  = 4096;
  localparam int ORDERS = 12;
  localparam int WATCHDOG_LIMIT = 40000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  req_t             req_i = '0;
  logic             strobe_o;
  rsp_t             rsp_o;
  logic             cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  int               fail_count, pending_rsp, alloc_ok_count, merge_count;
  int               idle_cycles = 0;
  int               txn_count;
  logic [IDX_W-1:0] owned_idx[$];
  logic [ORD_W-1:0] owned_ord[$];

  always #4 clk_i = ~clk_i;

  buddy_page_allocator_top #(.PAGES(PAGES), .ORDERS(ORDERS)) uut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .strobe_o, .rsp_o,
    .cfg_we_i, .cfg_wdata_i
  );

  buddy_page_allocator_checker #(.PAGES(PAGES), .ORDERS(ORDERS)) u_checker (
    .clk_i, .rst_ni, .start, .busy, .req_i, .strobe_o, .rsp_o,
    .cfg_we_i, .cfg_wdata_i, .fail_count, .pending_rsp,
    .alloc_ok_count, .merge_count
  );

  // watchdog: cycles with no transaction either way
  always @(posedge clk_i) begin
    if ((start && !busy) || strobe_o || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one command; gaps only when allowed
  task automatic send_cmd(logic [CMD_W-1:0] c, int o, int idx, bit gaps);
    if (gaps) begin
      while ($urandom_range(99) < 23) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{cmd: c, block_order: o[ORD_W-1:0], page_index: idx[IDX_W-1:0]};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    start <= 1'b0;
    txn_count++;
    // block is busy in the cycle after acceptance, so nothing is lost here
    @(posedge clk_i);
    // track what was handed out, for well-formed frees later
    if (c == CMD_ALLOC) begin
      while (!strobe_o) @(posedge clk_i);
      if (rsp_o.status == RES_OK) begin
        owned_idx.push_back(rsp_o.block_start);
        owned_ord.push_back(o[ORD_W-1:0]);
      end
    end else if (c == CMD_REBUILD) begin
      owned_idx.delete();
      owned_ord.delete();
    end
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending_rsp != 0 || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_pool(int n);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= n[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send_cmd(CMD_REBUILD, 0, 0, 1'b0);
  endtask

  task automatic random_phase(int n, bit gaps);
    int k, sel, o;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        o = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(4);
        send_cmd(CMD_ALLOC, o, $urandom_range(4095), gaps);
      end else if (sel < 85 && owned_idx.size() > 0) begin
        k = $urandom_range(owned_idx.size() - 1);
        send_cmd(CMD_FREE, owned_ord[k], owned_idx[k], gaps);
        owned_idx.delete(k);
        owned_ord.delete(k);
      end else if (sel < 97) begin
        send_cmd(CMD_FREE, $urandom_range(15), $urandom_range(4095), gaps);
      end else begin
        send_cmd(CMD_NOP, $urandom_range(15), $urandom_range(4095), gaps);
      end
    end
  endtask

  initial begin
    txn_count = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, each command and the rejection cases
    send_cmd(CMD_ALLOC, 11, 0, 1'b0);
    send_cmd(CMD_ALLOC, 0, 0, 1'b0);
    send_cmd(CMD_ALLOC, 15, 4095, 1'b0);
    send_cmd(CMD_ALLOC, 12, 0, 1'b0);
    send_cmd(CMD_FREE, 0, 4095, 1'b0);
    send_cmd(CMD_FREE, 12, 0, 1'b0);
    send_cmd(CMD_FREE, 3, 5, 1'b0);
    send_cmd(CMD_FREE, 0, 1, 1'b0);
    send_cmd(CMD_FREE, 11, 2048, 1'b0);
    send_cmd(CMD_NOP, 15, 4095, 1'b0);
    while (owned_idx.size() > 0) begin
      send_cmd(CMD_FREE, owned_ord[0], owned_idx[0], 1'b0);
      owned_idx.delete(0);
      owned_ord.delete(0);
    end
    send_cmd(CMD_FREE, 11, 0, 1'b0);

    set_pool(0);
    send_cmd(CMD_ALLOC, 0, 0, 1'b0);
    send_cmd(CMD_FREE, 0, 0, 1'b0);
    set_pool(8191);
    send_cmd(CMD_ALLOC, 11, 0, 1'b0);
    set_pool(2048 + 5);
    send_cmd(CMD_ALLOC, 0, 0, 1'b0);
    send_cmd(CMD_ALLOC, 2, 0, 1'b0);
    send_cmd(CMD_FREE, 0, 2052, 1'b0);

    // random phases over several pool sizes
    random_phase(300, 1'b0);
    drain(); // sender holds off until all results are in
    set_pool(1);
    random_phase(60, 1'b1);
    set_pool(4096);
    random_phase(400, 1'b1);
    set_pool($urandom_range(4095, 1));
    random_phase(300, 1'b1);
    set_pool(777);
    random_phase(330, 1'b1);
    send_cmd(CMD_REBUILD, 0, 0, 1'b1);
    random_phase(40, 1'b1);

    drain();
    $display("Ran %0d transactions: %0d successful allocations, %0d buddy merges.",
             txn_count, alloc_ok_count, merge_count);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

// ----- buddy_page_allocator_top.f -----
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_ram.sv
hw/rtl/bpa_ctrl.sv
hw/rtl/bpa_dpath.sv
hw/rtl/buddy_page_allocator_top.sv
tb/sv/buddy_page_allocator_checker.sv
tb/sv/buddy_page_allocator_top_test.sv
